// ===== hw/rtl/rsi_pkg.sv =====
package rsi_pkg;

  localparam int MUL_DIG     = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_INSIDE = 2'd1;
  localparam logic [1:0] HIT_TWO    = 2'd2;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } qrd_t;

endpackage

// ===== hw/rtl/rsi_fifo.sv =====
module rsi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNTW'(do_push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/rsi_mul.sv =====
module rsi_mul import rsi_pkg::*; #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int NDIG = (WB + MUL_DIG - 1) / MUL_DIG;
  localparam int BP   = NDIG * MUL_DIG;
  localparam int PW   = WA + BP;

  logic [WA-1:0]         a_r    [NDIG];
  logic [BP-1:0]         b_r    [NDIG];
  logic [PW-1:0]         acc_r  [NDIG];
  logic [WA-1:0]         a_in   [NDIG];
  logic [BP-1:0]         b_in   [NDIG];
  logic [PW-1:0]         acc_in [NDIG];
  logic [WA+MUL_DIG-1:0] pp     [NDIG];

  for (genvar k = 0; k < NDIG; k++) begin : g_stg
    if (k == 0) begin : g_first
      assign a_in[k]   = a;
      assign b_in[k]   = BP'(b);
      assign acc_in[k] = '0;
    end else begin : g_next
      assign a_in[k]   = a_r[k-1];
      assign b_in[k]   = b_r[k-1];
      assign acc_in[k] = acc_r[k-1];
    end

    assign pp[k] = a_in[k] * b_in[k][k*MUL_DIG +: MUL_DIG];

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in[k];
        b_r[k]   <= b_in[k];
        acc_r[k] <= acc_in[k] + (PW'(pp[k]) << (k * MUL_DIG));
      end
    end
  end

  assign p = acc_r[NDIG-1][WA+WB-1:0];

endmodule

// ===== hw/rtl/rsi_front.sv =====
module rsi_front #(
  parameter int CW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [2:0][CW-1:0]        org,
  input  logic [2:0][CW-1:0]        dir,
  input  logic [2:0][CW-1:0]        ctr,
  input  logic [CW-2:0]             rad,
  output logic                      q_push,
  input  logic                      q_full,
  output logic [6*CW+5:0]           q_data
);

  localparam int AW  = 2 * CW;
  localparam int HW  = 2 * CW + 2;
  localparam int CCW = 2 * CW + 3;

  logic en;
  logic s0_vld_r, s1_vld_r, s2_vld_r;

  logic signed [CW:0]       q_r  [3];
  logic signed [CW:0]       q_nxt[3];
  logic signed [CW-1:0]     v_r  [3];
  logic [CW-2:0]            r_r;

  logic signed [2*CW-1:0]   vv_r  [3];
  logic signed [2*CW-1:0]   vv_nxt[3];
  logic signed [2*CW:0]     qv_r  [3];
  logic signed [2*CW:0]     qv_nxt[3];
  logic signed [2*CW+1:0]   qq_r  [3];
  logic signed [2*CW+1:0]   qq_nxt[3];
  logic [2*CW-3:0]          rr_r;

  logic [AW-1:0]            a_r, a_nxt;
  logic signed [HW-1:0]     h_r, h_nxt;
  logic signed [CCW-1:0]    c_r, c_nxt;
  logic                     deg_r;

  assign en      = !(s2_vld_r && q_full);
  assign in_full = !en;
  assign q_push  = s2_vld_r && !q_full;
  assign q_data  = {deg_r, a_r, h_r, c_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_nxt[i]  = $signed({org[i][CW-1], org[i]}) - $signed({ctr[i][CW-1], ctr[i]});
      vv_nxt[i] = v_r[i] * v_r[i];
      qv_nxt[i] = q_r[i] * v_r[i];
      qq_nxt[i] = q_r[i] * q_r[i];
    end
    a_nxt = vv_r[0][AW-1:0] + vv_r[1][AW-1:0] + vv_r[2][AW-1:0];
    h_nxt = HW'(qv_r[0]) + HW'(qv_r[1]) + HW'(qv_r[2]);
    c_nxt = CCW'(qq_r[0]) + CCW'(qq_r[1]) + CCW'(qq_r[2]) - $signed({1'b0, rr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_push;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_r[i]  <= q_nxt[i];
        v_r[i]  <= $signed(dir[i]);
        vv_r[i] <= vv_nxt[i];
        qv_r[i] <= qv_nxt[i];
        qq_r[i] <= qq_nxt[i];
      end
      r_r   <= rad;
      rr_r  <= r_r * r_r;
      a_r   <= a_nxt;
      h_r   <= h_nxt;
      c_r   <= c_nxt;
      deg_r <= (a_nxt == '0);
    end
  end

endmodule

// ===== hw/rtl/rsi_back.sv =====
module rsi_back import rsi_pkg::*; #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [6*CW+5:0]   q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_hit_count,
  output logic [31:0]       out_near_distance,
  output logic [31:0]       out_far_distance,
  output logic              out_degenerate
);

  localparam int AW   = 2 * CW;
  localparam int HW   = 2 * CW + 2;
  localparam int CCW  = 2 * CW + 3;
  localparam int MW   = 2 * CW + 2;
  localparam int NDIG = (MW + MUL_DIG - 1) / MUL_DIG;
  localparam int PW   = 2 * MW;
  localparam int RW   = 2 * CW + 1;
  localparam int NW   = 2 * CW + 3;
  localparam int QW   = CW - 1;
  localparam int XA   = 2 * CW + 2 + F;
  localparam int XB   = 3 * CW - 1;
  localparam int XW   = ((XA > XB) ? XA : XB) + 1;

  typedef struct packed {
    logic          deg;
    logic          kill;
    logic          n1neg;
    logic          sat1;
    logic          sat2;
    logic          csgn;
    logic [HW-1:0] h;
    logic [AW-1:0] a;
  } side_t;

  logic en;

  // queue read stage
  logic                  b0_vld_r;
  logic                  b0_deg_r;
  logic [AW-1:0]         b0_a_r;
  logic signed [HW-1:0]  b0_h_r;
  logic signed [CCW-1:0] b0_c_r;
  logic [HW-1:0]         h_mag;
  logic [CCW-1:0]        c_abs;
  logic [PW-1:0]         h2, ac;
  side_t                 b0_side;

  // multiplier side line
  side_t m_side_r [NDIG];
  logic  m_vld_r  [NDIG];

  // discriminant stage
  logic [PW:0]     dval;
  logic            d_vld_r;
  side_t           d_side_r, d_side_nxt;
  logic [2*RW-1:0] d_rad_r;

  // square root stages
  logic [RW+1:0]   sq_rem_r  [RW];
  logic [RW-1:0]   sq_root_r [RW];
  logic [2*RW-1:0] sq_rad_r  [RW];
  side_t           sq_side_r [RW];
  logic            sq_vld_r  [RW];
  logic [RW+1:0]   sq_rem_in [RW];
  logic [RW-1:0]   sq_root_in[RW];
  logic [2*RW-1:0] sq_rad_in [RW];
  side_t           sq_side_in[RW];
  logic            sq_vld_in [RW];

  // root numerator stage
  logic signed [NW-1:0] hx, sx, n1, n2;
  side_t                n_side_r, n_side_nxt;
  logic                 n_vld_r;
  logic [XW-1:0]        n_num1_r, n_num2_r, n_num1_nxt, n_num2_nxt;

  // saturation stage
  logic [XW-1:0] sa;
  side_t         v_side_r, v_side_nxt;
  logic          v_vld_r;
  logic [XW-1:0] v_num1_r, v_num2_r;

  // divide stages
  logic [XW-1:0] dv_rem1_r [QW];
  logic [XW-1:0] dv_rem2_r [QW];
  logic [QW-1:0] dv_q1_r   [QW];
  logic [QW-1:0] dv_q2_r   [QW];
  side_t         dv_side_r [QW];
  logic          dv_vld_r  [QW];
  logic [XW-1:0] dv_rem1_in[QW];
  logic [XW-1:0] dv_rem2_in[QW];
  logic [QW-1:0] dv_q1_in  [QW];
  logic [QW-1:0] dv_q2_in  [QW];
  side_t         dv_side_in[QW];
  logic          dv_vld_in [QW];

  // output register
  logic        out_vld_r;
  logic [1:0]  o_hit_r, o_hit_nxt;
  logic [31:0] o_near_r, o_near_nxt, o_far_r, o_far_nxt;
  logic        o_deg_r;
  side_t       o_side;
  logic [QW-1:0] dmax;

  assign en        = !out_vld_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !out_vld_r;

  assign out_hit_count     = o_hit_r;
  assign out_near_distance = o_near_r;
  assign out_far_distance  = o_far_r;
  assign out_degenerate    = o_deg_r;

  // queue read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
    end else if (en) begin
      b0_vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {b0_deg_r, b0_a_r, b0_h_r, b0_c_r} <= q_data;
    end
  end

  always_comb begin
    h_mag         = b0_h_r[HW-1] ? HW'(-b0_h_r) : HW'(b0_h_r);
    c_abs         = b0_c_r[CCW-1] ? CCW'(-b0_c_r) : CCW'(b0_c_r);
    b0_side       = '0;
    b0_side.deg   = b0_deg_r;
    b0_side.csgn  = b0_c_r[CCW-1];
    b0_side.h     = b0_h_r;
    b0_side.a     = b0_a_r;
  end

  rsi_mul #(.WA(MW), .WB(MW)) u_mul_hh (
    .clk (clk),
    .en  (en),
    .a   (h_mag),
    .b   (h_mag),
    .p   (h2)
  );

  rsi_mul #(.WA(MW), .WB(MW)) u_mul_ac (
    .clk (clk),
    .en  (en),
    .a   (MW'(b0_a_r)),
    .b   (c_abs[MW-1:0]),
    .p   (ac)
  );

  for (genvar k = 0; k < NDIG; k++) begin : g_mside
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_vld_r[k] <= 1'b0;
      end else if (en) begin
        m_vld_r[k] <= (k == 0) ? b0_vld_r : m_vld_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_side_r[k] <= (k == 0) ? b0_side : m_side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // discriminant, negative means a miss
  always_comb begin
    d_side_nxt = m_side_r[NDIG-1];
    if (d_side_nxt.csgn) begin
      dval = {1'b0, h2} + {1'b0, ac};
    end else begin
      dval = {1'b0, h2} - {1'b0, ac};
    end
    d_side_nxt.kill = d_side_nxt.deg || dval[PW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= m_vld_r[NDIG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= d_side_nxt;
      d_rad_r  <= dval[PW] ? '0 : dval[2*RW-1:0];
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RW+1:0] cur, trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign sq_rem_in[i]  = '0;
      assign sq_root_in[i] = '0;
      assign sq_rad_in[i]  = d_rad_r;
      assign sq_side_in[i] = d_side_r;
      assign sq_vld_in[i]  = d_vld_r;
    end else begin : g_next
      assign sq_rem_in[i]  = sq_rem_r[i-1];
      assign sq_root_in[i] = sq_root_r[i-1];
      assign sq_rad_in[i]  = sq_rad_r[i-1];
      assign sq_side_in[i] = sq_side_r[i-1];
      assign sq_vld_in[i]  = sq_vld_r[i-1];
    end

    assign cur   = {sq_rem_in[i][RW-1:0], sq_rad_in[i][2*RW-1 -: 2]};
    assign trial = {sq_root_in[i], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i] <= sq_vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[i]  <= ge ? cur - trial : cur;
        sq_root_r[i] <= {sq_root_in[i][RW-2:0], ge};
        sq_rad_r[i]  <= {sq_rad_in[i][2*RW-3:0], 2'b00};
        sq_side_r[i] <= sq_side_in[i];
      end
    end
  end

  // root numerators
  always_comb begin
    n_side_nxt       = sq_side_r[RW-1];
    hx               = $signed({{(NW - HW){n_side_nxt.h[HW-1]}}, n_side_nxt.h});
    sx               = $signed({{(NW - RW){1'b0}}, sq_root_r[RW-1]});
    n1               = -hx - sx;
    n2               = -hx + sx;
    n_side_nxt.kill  = n_side_nxt.kill || n2[NW-1];
    n_side_nxt.n1neg = n1[NW-1];
    n_num1_nxt       = n1[NW-1] ? '0 : (XW'(n1[NW-2:0]) << F);
    n_num2_nxt       = n2[NW-1] ? '0 : (XW'(n2[NW-2:0]) << F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
      v_vld_r <= 1'b0;
    end else if (en) begin
      n_vld_r <= sq_vld_r[RW-1];
      v_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_side_r <= n_side_nxt;
      n_num1_r <= n_num1_nxt;
      n_num2_r <= n_num2_nxt;
    end
  end

  // saturation check against the full quotient range
  always_comb begin
    v_side_nxt      = n_side_r;
    sa              = XW'(n_side_r.a) << QW;
    v_side_nxt.sat1 = (n_num1_r >= sa);
    v_side_nxt.sat2 = (n_num2_r >= sa);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_side_r <= v_side_nxt;
      v_num1_r <= n_num1_r;
      v_num2_r <= n_num2_r;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [XW-1:0] dv;
    logic          ge1, ge2;

    if (j == 0) begin : g_first
      assign dv_rem1_in[j] = v_num1_r;
      assign dv_rem2_in[j] = v_num2_r;
      assign dv_q1_in[j]   = '0;
      assign dv_q2_in[j]   = '0;
      assign dv_side_in[j] = v_side_r;
      assign dv_vld_in[j]  = v_vld_r;
    end else begin : g_next
      assign dv_rem1_in[j] = dv_rem1_r[j-1];
      assign dv_rem2_in[j] = dv_rem2_r[j-1];
      assign dv_q1_in[j]   = dv_q1_r[j-1];
      assign dv_q2_in[j]   = dv_q2_r[j-1];
      assign dv_side_in[j] = dv_side_r[j-1];
      assign dv_vld_in[j]  = dv_vld_r[j-1];
    end

    assign dv  = XW'(dv_side_in[j].a) << (QW - 1 - j);
    assign ge1 = (dv_rem1_in[j] >= dv);
    assign ge2 = (dv_rem2_in[j] >= dv);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j] <= dv_vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem1_r[j] <= ge1 ? dv_rem1_in[j] - dv : dv_rem1_in[j];
        dv_rem2_r[j] <= ge2 ? dv_rem2_in[j] - dv : dv_rem2_in[j];
        dv_q1_r[j]   <= {dv_q1_in[j][QW-2:0], ge1};
        dv_q2_r[j]   <= {dv_q2_in[j][QW-2:0], ge2};
        dv_side_r[j] <= dv_side_in[j];
      end
    end
  end

  // result formatting
  always_comb begin
    dmax       = '1;
    o_side     = dv_side_r[QW-1];
    o_hit_nxt  = HIT_NONE;
    o_near_nxt = '0;
    o_far_nxt  = '0;
    if (!o_side.kill) begin
      o_far_nxt = 32'(o_side.sat2 ? dmax : dv_q2_r[QW-1]);
      if (o_side.n1neg) begin
        o_hit_nxt = HIT_INSIDE;
      end else begin
        o_hit_nxt  = HIT_TWO;
        o_near_nxt = 32'(o_side.sat1 ? dmax : dv_q1_r[QW-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit_r  <= o_hit_nxt;
      o_near_r <= o_near_nxt;
      o_far_r  <= o_far_nxt;
      o_deg_r  <= o_side.deg;
    end
  end

endmodule

// ===== hw/rtl/ray_sphere_intersection.sv =====
// Pipeline: front stages, the coefficient queue, a queue read stage, the digit multipliers,
//   the discriminant, square root, numerator, saturation, divide and output registers.
// Throughput: one request per cycle while no stall holds the pipeline; the square root and
//   divide units are fully pipelined. The front stalls only when the coefficient queue is
//   full, the back only when the result is held with pop low.
// Reset: synchronous, active low; clears all valid bits and queue pointers.
module ray_sphere_intersection import rsi_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_center_x,
  input  logic [31:0] in_center_y,
  input  logic [31:0] in_center_z,
  input  logic [30:0] in_radius,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_hit_count,
  output logic [31:0] out_near_distance,
  output logic [31:0] out_far_distance,
  output logic        out_degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int QDW = 6 * CW + 6;

  logic [2:0][CW-1:0] org, dir, ctr;
  logic [QDW-1:0]     q_wdata, q_rdata;
  qwr_t               qwr;
  qrd_t               qrd;

  assign org = {in_origin_z[CW-1:0], in_origin_y[CW-1:0], in_origin_x[CW-1:0]};
  assign dir = {in_dir_z[CW-1:0], in_dir_y[CW-1:0], in_dir_x[CW-1:0]};
  assign ctr = {in_center_z[CW-1:0], in_center_y[CW-1:0], in_center_x[CW-1:0]};

  rsi_front #(.CW(CW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .org     (org),
    .dir     (dir),
    .ctr     (ctr),
    .rad     (in_radius[CW-2:0]),
    .q_push  (qwr.push),
    .q_full  (qwr.full),
    .q_data  (q_wdata)
  );

  rsi_fifo #(.W(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qwr.push),
    .din   (q_wdata),
    .full  (qwr.full),
    .pop   (qrd.pop),
    .dout  (q_rdata),
    .empty (qrd.empty)
  );

  rsi_back #(.CW(CW), .F(FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (qrd.empty),
    .q_data            (q_rdata),
    .q_pop             (qrd.pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_hit_count     (out_hit_count),
    .out_near_distance (out_near_distance),
    .out_far_distance  (out_far_distance),
    .out_degenerate    (out_degenerate)
  );

  a_deg_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_degenerate) |-> (out_hit_count == HIT_NONE))
    else $error("degenerate ray reported a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_hit_count == HIT_NONE) |->
      (out_near_distance == 32'd0 && out_far_distance == 32'd0))
    else $error("miss with nonzero distance");

  a_near_le_far: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_hit_count == HIT_TWO) |->
      (out_near_distance <= out_far_distance))
    else $error("near distance beyond far distance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_far_distance)))
    else $error("held result changed");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (qrd.pop) |-> (!qrd.empty))
    else $error("queue read while empty");

endmodule
